[sv/websocket_frame_deframer_macros.svh]
// Assertion macros shared by the deframer's checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/wsd_pkg.sv]
`default_nettype none

package wsd_pkg;

  // Default width of the kept frame length.
  localparam int unsigned LEN_BITS_DEF = 32;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam logic [0:0]  REG_MAX_PAYLOAD = 1'b0;
  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd2048;

  // Stream widths.
  localparam int unsigned TDATA_W = 8;
  localparam int unsigned TUSER_W = 7;

  // Header constants.
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
  localparam logic [3:0] OPC_CLOSE      = 4'h8;
  localparam logic [3:0] OPC_PING       = 4'h9;
  localparam logic [3:0] OPC_PONG       = 4'hA;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    KIND_BYTE  = 3'd0,
    KIND_EMPTY = 3'd1,
    KIND_CLOSE = 3'd2,
    KIND_PING  = 3'd3,
    KIND_PONG  = 3'd4,
    KIND_BIG   = 3'd5
  } kind_e;

  // One result item handed from the parser to the output register.
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic       last;
    logic [3:0] opcode;
  } res_t;

  // Kind reported when a frame completes; KIND_BYTE means a data frame.
  function automatic kind_e control_kind(input logic [3:0] opcode);
    kind_e k;
    case (opcode)
      OPC_CLOSE: k = KIND_CLOSE;
      OPC_PING:  k = KIND_PING;
      OPC_PONG:  k = KIND_PONG;
      default:   k = KIND_BYTE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[sv/wsd_in_stage.sv]
`default_nettype none

// Input register: holds one received byte until the parser takes it.
module wsd_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  wire logic       advance_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  // A new item may enter when the register is empty or is being drained.
  assign s_axis_tready = !valid_q || advance_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= s_axis_tdata;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

[sv/wsd_parse.sv]
`default_nettype none

// Frame parser: one byte per step, all state updated in a single pass.
module wsd_parse #(
  parameter int unsigned LEN_BITS = wsd_pkg::LEN_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic [31:0] max_payload_i,
  output wsd_pkg::res_t    res_o
);

  wsd_pkg::phase_e     phase_q, phase_d;
  logic [2:0]          hdr_cnt_q, hdr_cnt_d;
  logic [LEN_BITS-1:0] total_len_q, total_len_d;
  logic [LEN_BITS-1:0] remain_q, remain_d;
  logic [31:0]         mask_key_q, mask_key_d;
  logic [1:0]          mask_idx_q, mask_idx_d;
  logic                masked_q, masked_d;
  logic [3:0]          opcode_q, opcode_d;
  logic                discard_q, discard_d;

  wsd_pkg::res_t       res;
  wsd_pkg::kind_e      ck;
  logic [6:0]          len_code;
  logic [7:0]          key_byte;
  logic [7:0]          plain;
  logic                after_len;
  logic                do_finish;
  logic                rem_zero;

  assign len_code = byte_i[6:0];
  assign ck       = wsd_pkg::control_kind(opcode_q);
  // Key bytes are applied in arrival order, first byte held in the top bits.
  assign key_byte = mask_key_q[{~mask_idx_q, 3'b000} +: 8];
  assign plain    = masked_q ? (byte_i ^ key_byte) : byte_i;

  // Next state and result for the byte at the head of the input register.
  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    total_len_d = total_len_q;
    remain_d    = remain_q;
    mask_key_d  = mask_key_q;
    mask_idx_d  = mask_idx_q;
    masked_d    = masked_q;
    opcode_d    = opcode_q;
    discard_d   = discard_q;
    res         = '0;
    after_len   = 1'b0;
    do_finish   = 1'b0;
    rem_zero    = 1'b0;

    case (phase_q)
      wsd_pkg::PH_HDR1: begin
        masked_d    = byte_i[7];
        total_len_d = '0;
        hdr_cnt_d   = '0;
        if (len_code == wsd_pkg::LEN_CODE_EXT16) begin
          phase_d = wsd_pkg::PH_EXT16;
        end else if (len_code == wsd_pkg::LEN_CODE_EXT64) begin
          phase_d = wsd_pkg::PH_EXT64;
        end else begin
          total_len_d = LEN_BITS'(len_code);
          after_len   = 1'b1;
        end
      end
      wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
        // Only the low bits of a long length survive the shift.
        total_len_d = {total_len_q[LEN_BITS-9:0], byte_i};
        hdr_cnt_d   = hdr_cnt_q + 3'd1;
        if ((phase_q == wsd_pkg::PH_EXT16 && hdr_cnt_d == 3'd2) ||
            (phase_q == wsd_pkg::PH_EXT64 && hdr_cnt_d == 3'd0)) begin
          after_len = 1'b1;
        end
      end
      wsd_pkg::PH_MASK: begin
        mask_key_d = {mask_key_q[23:0], byte_i};
        hdr_cnt_d  = hdr_cnt_q + 3'd1;
        if (hdr_cnt_d == 3'd4) begin
          do_finish = 1'b1;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        mask_idx_d = mask_idx_q + 2'd1;
        remain_d   = remain_q - LEN_BITS'(1);
        rem_zero   = (remain_d == '0);
        if (rem_zero) begin
          phase_d = wsd_pkg::PH_HDR0;
        end
        if (discard_q) begin
          if (rem_zero) begin
            discard_d = 1'b0;
          end
        end else if (ck == wsd_pkg::KIND_BYTE) begin
          res.valid = 1'b1;
          res.kind  = wsd_pkg::KIND_BYTE;
          res.data  = plain;
          res.last  = rem_zero;
        end else if (rem_zero) begin
          res.valid = 1'b1;
          res.kind  = ck;
          res.last  = 1'b1;
        end
      end
      default: begin
        // First header byte; unused phase codes land here too.
        opcode_d  = byte_i[3:0];
        discard_d = 1'b0;
        hdr_cnt_d = '0;
        phase_d   = wsd_pkg::PH_HDR1;
      end
    endcase

    // Length complete: collect the mask key or close the header.
    if (after_len) begin
      hdr_cnt_d = '0;
      if (masked_d) begin
        phase_d = wsd_pkg::PH_MASK;
      end else begin
        do_finish = 1'b1;
      end
    end

    // Header end: size check first, then empty frames.
    if (do_finish) begin
      remain_d   = total_len_d;
      mask_idx_d = '0;
      hdr_cnt_d  = '0;
      if (32'(total_len_d) >= max_payload_i) begin
        res.valid = 1'b1;
        res.kind  = wsd_pkg::KIND_BIG;
        res.last  = 1'b1;
        if (total_len_d == '0) begin
          phase_d = wsd_pkg::PH_HDR0;
        end else begin
          discard_d = 1'b1;
          phase_d   = wsd_pkg::PH_PAYLOAD;
        end
      end else if (total_len_d == '0) begin
        res.valid = 1'b1;
        res.kind  = (ck == wsd_pkg::KIND_BYTE) ? wsd_pkg::KIND_EMPTY : ck;
        res.last  = 1'b1;
        phase_d   = wsd_pkg::PH_HDR0;
      end else begin
        phase_d = wsd_pkg::PH_PAYLOAD;
      end
    end

    res.opcode = opcode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wsd_pkg::PH_HDR0;
      hdr_cnt_q   <= '0;
      total_len_q <= '0;
      remain_q    <= '0;
      mask_key_q  <= '0;
      mask_idx_q  <= '0;
      masked_q    <= 1'b0;
      opcode_q    <= '0;
      discard_q   <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      total_len_q <= total_len_d;
      remain_q    <= remain_d;
      mask_key_q  <= mask_key_d;
      mask_idx_q  <= mask_idx_d;
      masked_q    <= masked_d;
      opcode_q    <= opcode_d;
      discard_q   <= discard_d;
    end
  end

  always_comb begin
    res_o       = res;
    res_o.valid = res.valid && step_i;
  end

endmodule

`default_nettype wire

[sv/wsd_out_stage.sv]
`default_nettype none

// Result register: holds one result item until the receiver takes it.
module wsd_out_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire wsd_pkg::res_t res_i,
  output logic            ready_o,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] data_byte
  output logic [6:0]      m_axis_tuser,   // [2:0] kind, [6:3] frame_opcode
  output logic            m_axis_tlast    // last
);

  logic          valid_q, valid_d;
  wsd_pkg::res_t res_q;

  // Free when empty or when the held item leaves this cycle.
  assign ready_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (res_i.valid) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = res_q.data;
  assign m_axis_tuser  = {res_q.opcode, res_q.kind};
  assign m_axis_tlast  = res_q.last;

endmodule

`default_nettype wire

[sv/websocket_frame_deframer.sv]
// WebSocket frame deframer, receive side.
// The slave stream carries the raw connection bytes, one per item in tdata.
// The master stream carries one result item per payload byte of a data
// frame (kind 0, unmasked byte in tdata, tlast on the frame's final byte),
// and one item with tlast set for an empty data frame, for a completed
// close, ping or pong frame, or for a frame whose length reaches
// max_payload (whose payload is then dropped). tuser holds kind and the
// frame's opcode. Header bytes produce no item, except the byte that ends
// the header of an empty or oversized frame.
// A byte is accepted into an input register, parsed in one pass and its
// result is registered in the output register once that has room. One byte
// is taken every cycle while the receiver keeps tready high; the single
// parse pass per byte sets that rate. When the receiver stalls, the output
// register holds its item, the input register fills, and s_axis_tready
// falls until the output drains. Reset clears both registers and returns
// the parser to waiting for a first header byte; max_payload returns to
// 2048. The APB port holds max_payload at address 0. The user must write
// it only while the stream is idle; the block does not enforce this.
`default_nettype none

module websocket_frame_deframer #(
  parameter int unsigned LEN_BITS = wsd_pkg::LEN_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Raw byte stream in.
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [wsd_pkg::TDATA_W-1:0]    s_axis_tdata,   // [7:0] rx_byte
  // Result stream out.
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [wsd_pkg::TDATA_W-1:0]         m_axis_tdata,   // [7:0] data_byte
  output logic [wsd_pkg::TUSER_W-1:0]         m_axis_tuser,   // [2:0] kind, [6:3] frame_opcode
  output logic                                m_axis_tlast,   // last
  // Configuration.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [wsd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [wsd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [wsd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          out_ready;
  logic          advance;
  wsd_pkg::res_t res;
  logic [31:0]   max_payload_q;
  logic [0:0]    reg_idx;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= wsd_pkg::MAX_PAYLOAD_RST;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx == wsd_pkg::REG_MAX_PAYLOAD) begin
      max_payload_q <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == wsd_pkg::REG_MAX_PAYLOAD) begin
      prdata = max_payload_q;
    end
  end

  // The held byte moves on whenever the result register has room.
  assign advance = in_valid && out_ready;

  wsd_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance_i     (advance),
    .valid_o       (in_valid),
    .byte_o        (in_byte)
  );

  wsd_parse #(
    .LEN_BITS (LEN_BITS)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (in_byte),
    .max_payload_i (max_payload_q),
    .res_o         (res)
  );

  wsd_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

[sv/wsd_checker.sv]
`default_nettype none

`include "websocket_frame_deframer_macros.svh"

// Port-level checks on the deframer's result stream.
module wsd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [wsd_pkg::TDATA_W-1:0] m_axis_tdata,
  input wire logic [wsd_pkg::TUSER_W-1:0] m_axis_tuser,
  input wire logic                        m_axis_tlast
);

  // Any item other than a payload byte closes its frame.
  `WSD_ASSERT_IMPLY(a_ctrl_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[2:0] != wsd_pkg::KIND_BYTE, m_axis_tlast, "non-byte item without tlast")

  // Only payload bytes carry data.
  `WSD_ASSERT_IMPLY(a_ctrl_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[2:0] != wsd_pkg::KIND_BYTE, m_axis_tdata == '0, "non-byte item with data")

  // The kind code stays within the defined kinds.
  `WSD_ASSERT_IMPLY(a_kind_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser[2:0] <= wsd_pkg::KIND_BIG, "undefined kind code")

  // A stalled result item holds until taken.
  `WSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled item changed")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);

`default_nettype wire

[verif/tb_websocket_frame_deframer.sv]
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned DRAIN_SETTLE  = 8;
  localparam int unsigned PHASE_ITEMS   = 290;
  localparam int unsigned REPORT_CAP    = 40;
  localparam int unsigned LONGEST_FRAME = 300;
  localparam logic [wsd_pkg::CFG_ADDR_W-1:0] ADDR_MAX_PAYLOAD =
    wsd_pkg::CFG_ADDR_W'(4 * wsd_pkg::REG_MAX_PAYLOAD);
  localparam logic [wsd_pkg::CFG_ADDR_W-1:0] ADDR_SPARE = wsd_pkg::CFG_ADDR_W'(4);

  typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;
  typedef enum {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_MOSTLY} sink_mode_e;

  typedef struct {
    wsd_pkg::kind_e kind;
    logic [7:0]     data;
    logic           last;
    logic [3:0]     opcode;
  } frame_result_t;

  // Tracks the parser state and holds the results that accepted bytes will cause.
  class deframe_scoreboard;
    frame_result_t   expected_q[$];
    int unsigned     errors;
    logic [31:0]     max_payload;
    wsd_pkg::phase_e phase;
    logic [2:0]      hdr_count;
    logic [31:0]     total_len;
    logic [31:0]     remaining;
    logic [31:0]     mask_key;
    logic [1:0]      key_index;
    logic            masked;
    logic            dropping;
    logic [3:0]      opcode;

    function new();
      errors      = 0;
      max_payload = wsd_pkg::MAX_PAYLOAD_RST;
      phase       = wsd_pkg::PH_HDR0;
      hdr_count   = '0;
      total_len   = '0;
      remaining   = '0;
      mask_key    = '0;
      key_index   = '0;
      masked      = 1'b0;
      dropping    = 1'b0;
      opcode      = '0;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= REPORT_CAP) $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Only index 0 exists; writes elsewhere leave the limit alone.
    function void write_reg(input int unsigned index, input logic [31:0] value);
      if (index == wsd_pkg::REG_MAX_PAYLOAD) max_payload = value;
    endfunction

    function void queue_result(input wsd_pkg::kind_e kind, input logic [7:0] data,
                               input logic last);
      frame_result_t r;
      r.kind   = kind;
      r.data   = data;
      r.last   = last;
      r.opcode = opcode;
      expected_q.push_back(r);
    endfunction

    // Close, ping and pong report their own kind; everything else is data.
    function wsd_pkg::kind_e completion_kind();
      if (opcode == wsd_pkg::OPC_CLOSE) return wsd_pkg::KIND_CLOSE;
      if (opcode == wsd_pkg::OPC_PING) return wsd_pkg::KIND_PING;
      if (opcode == wsd_pkg::OPC_PONG) return wsd_pkg::KIND_PONG;
      return wsd_pkg::KIND_BYTE;
    endfunction

    // Header complete: the size check comes first, then empty frames.
    function void close_header();
      wsd_pkg::kind_e k;
      k         = completion_kind();
      remaining = total_len;
      key_index = '0;
      hdr_count = '0;
      if (total_len >= max_payload) begin
        queue_result(wsd_pkg::KIND_BIG, 8'h00, 1'b1);
        if (total_len == 0) begin
          phase = wsd_pkg::PH_HDR0;
        end else begin
          dropping = 1'b1;
          phase    = wsd_pkg::PH_PAYLOAD;
        end
      end else if (total_len == 0) begin
        queue_result((k == wsd_pkg::KIND_BYTE) ? wsd_pkg::KIND_EMPTY : k, 8'h00, 1'b1);
        phase = wsd_pkg::PH_HDR0;
      end else begin
        phase = wsd_pkg::PH_PAYLOAD;
      end
    endfunction

    function void length_done();
      hdr_count = '0;
      if (masked) phase = wsd_pkg::PH_MASK;
      else close_header();
    endfunction

    function void note_byte(input logic [7:0] b);
      logic [6:0]     code;
      logic [7:0]     plain;
      wsd_pkg::kind_e k;
      case (phase)
        wsd_pkg::PH_HDR1: begin
          masked    = b[7];
          code      = b[6:0];
          total_len = '0;
          hdr_count = '0;
          if (code == wsd_pkg::LEN_CODE_EXT16) begin
            phase = wsd_pkg::PH_EXT16;
          end else if (code == wsd_pkg::LEN_CODE_EXT64) begin
            phase = wsd_pkg::PH_EXT64;
          end else begin
            total_len = 32'(code);
            length_done();
          end
        end
        wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
          // A 64-bit length keeps only its low 32 bits as the bytes shift in.
          total_len = {total_len[23:0], b};
          hdr_count = hdr_count + 3'd1;
          if ((phase == wsd_pkg::PH_EXT16 && hdr_count == 3'd2) ||
              (phase == wsd_pkg::PH_EXT64 && hdr_count == 3'd0))
            length_done();
        end
        wsd_pkg::PH_MASK: begin
          mask_key  = {mask_key[23:0], b};
          hdr_count = hdr_count + 3'd1;
          if (hdr_count == 3'd4) close_header();
        end
        wsd_pkg::PH_PAYLOAD: begin
          plain = b;
          if (masked) plain = b ^ 8'(mask_key >> (8 * (3 - int'(key_index))));
          key_index = key_index + 2'd1;
          remaining = remaining - 32'd1;
          if (remaining == 0) phase = wsd_pkg::PH_HDR0;
          if (dropping) begin
            if (remaining == 0) dropping = 1'b0;
          end else begin
            k = completion_kind();
            if (k == wsd_pkg::KIND_BYTE)
              queue_result(wsd_pkg::KIND_BYTE, plain, remaining == 0);
            else if (remaining == 0) queue_result(k, 8'h00, 1'b1);
          end
        end
        default: begin
          opcode    = b[3:0];
          dropping  = 1'b0;
          hdr_count = '0;
          phase     = wsd_pkg::PH_HDR1;
        end
      endcase
    endfunction

    task check_result(input logic [2:0] kind, input logic [7:0] data, input logic last,
                      input logic [3:0] opc);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d data %02h last %0b opcode %0h",
                         kind, data, last, opc));
      end else begin
        want = expected_q.pop_front();
        if (kind !== want.kind || data !== want.data || last !== want.last ||
            opc !== want.opcode)
          report($sformatf({"result kind %0d data %02h last %0b opcode %0h, ",
                            "wanted kind %0d data %02h last %0b opcode %0h"},
                           kind, data, last, opc,
                           want.kind, want.data, want.last, want.opcode));
      end
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [wsd_pkg::TDATA_W-1:0]    s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [wsd_pkg::TDATA_W-1:0]    m_axis_tdata;
  logic [wsd_pkg::TUSER_W-1:0]    m_axis_tuser;
  logic                           m_axis_tlast;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [wsd_pkg::CFG_ADDR_W-1:0] paddr;
  logic [wsd_pkg::CFG_DATA_W-1:0] pwdata;
  logic [wsd_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  bit          hold_request;
  int unsigned sent_count;
  int unsigned burst_left;
  int unsigned cycle_count = 0;

  deframe_scoreboard board;

  websocket_frame_deframer dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #5 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tuser[2:0], m_axis_tdata, m_axis_tlast, m_axis_tuser[6:3]);
  end

  // Result side: the stall pattern changes periodically, plus one long hold.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned tick;
    sink_mode_e  mode;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    tick          = 0;
    mode          = SINK_OPEN;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (tick % 48 == 0) mode = sink_mode_e'($urandom_range(0, 3));
      tick++;
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:   m_axis_tready <= 1'b1;
          SINK_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          SINK_SLOW:   m_axis_tready <= (tick % 4 == 0);
          default:     m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Offers one byte, in bursts separated by random gaps.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
    board.note_byte(b);
  endtask

  // Stops offering and waits for every predicted result, then lets the pipe settle.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [wsd_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.write_reg(int'(addr) / 4, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Builds one frame; a truncated frame stops somewhere before its end.
  task automatic send_frame(input logic [3:0] opc, input int unsigned len, input logic mask_on,
                            input len_form_e form, input logic [31:0] len_hi,
                            input bit truncate);
    logic [7:0]  frame_q[$];
    logic [31:0] key;
    int unsigned stop;
    frame_q.push_back({4'($urandom), opc});
    case (form)
      LEN_SHORT: frame_q.push_back({mask_on, 7'(len)});
      LEN_EXT16: begin
        frame_q.push_back({mask_on, wsd_pkg::LEN_CODE_EXT16});
        frame_q.push_back(len[15:8]);
        frame_q.push_back(len[7:0]);
      end
      default: begin
        frame_q.push_back({mask_on, wsd_pkg::LEN_CODE_EXT64});
        for (int i = 3; i >= 0; i--) frame_q.push_back(len_hi[8*i +: 8]);
        for (int i = 3; i >= 0; i--) frame_q.push_back(len[8*i +: 8]);
      end
    endcase
    if (mask_on) begin
      key = $urandom;
      for (int i = 3; i >= 0; i--) frame_q.push_back(key[8*i +: 8]);
    end
    repeat (len) frame_q.push_back(8'($urandom));
    stop = truncate ? $urandom_range(1, frame_q.size() - 1) : frame_q.size();
    for (int i = 0; i < stop; i++) send_byte(frame_q[i]);
  endtask

  // Feeds bytes that keep lengths short until the parser is back at a frame start.
  task automatic resync();
    logic [7:0] b;
    while (board.phase != wsd_pkg::PH_HDR0) begin
      b = 8'($urandom);
      case (board.phase)
        wsd_pkg::PH_HDR1:
          b[6:0] = 7'($urandom_range(0, wsd_pkg::LEN_CODE_EXT16 - 1));
        wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: b = 8'h00;
        default: ;
      endcase
      send_byte(b);
    end
  endtask

  task automatic random_frame();
    logic [3:0]  opc;
    logic [7:0]  b;
    int unsigned len;
    int unsigned pick;
    int unsigned roll;
    len_form_e   form;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      // Garbage from a frame start; a length code never asks for an extended length.
      repeat ($urandom_range(1, 5)) begin
        b = 8'($urandom);
        if (board.phase == wsd_pkg::PH_HDR1 && b[6:0] >= wsd_pkg::LEN_CODE_EXT16)
          b[6:0] = 7'($urandom_range(0, wsd_pkg::LEN_CODE_EXT16 - 1));
        send_byte(b);
      end
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          case ($urandom_range(0, 2))
            0:       opc = wsd_pkg::OPC_CLOSE;
            1:       opc = wsd_pkg::OPC_PING;
            default: opc = wsd_pkg::OPC_PONG;
          endcase
        end
        1:       opc = 4'($urandom);
        default: opc = 4'($urandom_range(0, 2));
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 50) len = $urandom_range(0, 20);
      else if (roll < 85) len = $urandom_range(21, wsd_pkg::LEN_CODE_EXT16 - 1);
      else len = $urandom_range(wsd_pkg::LEN_CODE_EXT16, LONGEST_FRAME);
      roll = $urandom_range(0, 9);
      if (len < wsd_pkg::LEN_CODE_EXT16)
        form = (roll < 7) ? LEN_SHORT : (roll < 9) ? LEN_EXT16 : LEN_EXT64;
      else
        form = (roll < 7) ? LEN_EXT16 : LEN_EXT64;
      send_frame(opc, len, 1'($urandom), form,
                 ($urandom_range(0, 1) == 0) ? 32'h0 : 32'($urandom), pick == 1);
    end
    resync();
  endtask

  initial begin : stimulus
    logic [31:0] ceilings[6];
    int unsigned phase_end;
    board         = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_request  = 1'b0;
    sent_count    = 0;
    burst_left    = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed frames at the reset limit: each length form, masking, every kind but the oversized one.
    send_frame(4'h1, 1, 1'b0, LEN_SHORT, 32'h0, 1'b0);
    send_frame(4'h2, 2, 1'b1, LEN_EXT16, 32'h0, 1'b0);
    send_frame(4'h0, 0, 1'b0, LEN_SHORT, 32'h0, 1'b0);
    send_frame(wsd_pkg::OPC_CLOSE, 0, 1'b0, LEN_SHORT, 32'h0, 1'b0);
    send_frame(wsd_pkg::OPC_PING, 1, 1'b1, LEN_SHORT, 32'h0, 1'b0);
    send_frame(wsd_pkg::OPC_PONG, 2, 1'b0, LEN_SHORT, 32'h0, 1'b0);
    send_frame(4'hF, 1, 1'b1, LEN_EXT64, 32'hFFFF_FFFF, 1'b0);
    send_frame(4'h3, 0, 1'b1, LEN_SHORT, 32'h0, 1'b0);

    // A write to an unused address must leave the limit unchanged.
    drain_results();
    apb_write(ADDR_SPARE, 32'd0);
    send_frame(4'h1, 3, 1'b0, LEN_SHORT, 32'h0, 1'b0);

    // Small limit: frames at the limit are rejected and their payload dropped.
    drain_results();
    apb_write(ADDR_MAX_PAYLOAD, 32'd3);
    send_frame(4'h2, 3, 1'b0, LEN_SHORT, 32'h0, 1'b0);
    send_frame(wsd_pkg::OPC_PING, 2, 1'b1, LEN_SHORT, 32'h0, 1'b0);
    send_frame(wsd_pkg::OPC_CLOSE, 5, 1'b0, LEN_SHORT, 32'h0, 1'b0);
    send_frame(4'h1, 3, 1'b1, LEN_EXT16, 32'h0, 1'b0);

    // Lowest limit: empty frames still pass, any payload is too large.
    drain_results();
    apb_write(ADDR_MAX_PAYLOAD, 32'd1);
    send_frame(4'h1, 0, 1'b0, LEN_SHORT, 32'h0, 1'b0);
    send_frame(4'h1, 1, 1'b0, LEN_SHORT, 32'h0, 1'b0);

    // Random frames under a series of limits.
    ceilings[0] = 32'd1;
    ceilings[1] = 32'hFFFF_FFFF;
    ceilings[2] = 32'($urandom_range(2, 40));
    ceilings[3] = wsd_pkg::MAX_PAYLOAD_RST;
    ceilings[4] = 32'($urandom) | 32'h0001_0000;
    ceilings[5] = 32'(wsd_pkg::LEN_CODE_EXT16);
    foreach (ceilings[p]) begin
      drain_results();
      if (p == 2) apb_write(ADDR_SPARE, 32'($urandom));
      apb_write(ADDR_MAX_PAYLOAD, ceilings[p]);
      // Long receiver hold while the sender keeps pushing, so the block backs up.
      if (p == 1) begin
        hold_request = 1'b1;
        burst_left   = 150;
      end
      phase_end = sent_count + PHASE_ITEMS;
      while (sent_count < phase_end) random_frame();
    end

    drain_results();
    if (board.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
